### hw/rtl/iaps_pkg.sv
// Shared types, widths and constants for the intercept aim point solver.
package iaps_pkg;

   // Iteration limit of the Newton solve.
   localparam int MAX_ITERATIONS = 20;
   localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);

   // Datapath widths, sized from the ranges of the Q16.16 quantities.
   localparam int T_W     = 24;  // iterate t, saturated to +/-64 s
   localparam int T2_W    = 30;  // t*t in Q16.16
   localparam int POS_W   = 46;  // predicted x position
   localparam int MAG_W   = 45;  // magnitude of dx or dy
   localparam int SH_W    = 4;   // normalizing shift count
   localparam int DXDT_W  = 40;  // x velocity at t
   localparam int DIST_W  = 46;  // distance after scaling back
   localparam int RAT_W   = 26;  // signed Q1.24 direction ratio
   localparam int F_W     = 48;  // residual
   localparam int DF_W    = 41;  // derivative of the residual
   localparam int OUT_T_W = 18;  // Q2.16 output time

   // Shared multiplier operand widths.
   localparam int MA_W = 40;
   localparam int MB_W = 33;
   localparam int MP_W = 64;

   // Shared divider operand widths.
   localparam int NUM_W = 63;
   localparam int DEN_W = 41;

   // Time constants in Q16.16.
   localparam logic signed [T_W-1:0] T_START  = T_W'(32768);
   localparam logic signed [T_W-1:0] T_MIN    = T_W'(655);
   localparam logic signed [T_W-1:0] T_MAX    = T_W'(196608);
   localparam logic signed [63:0]    T_SAT    = 64'sd4194304;
   localparam logic signed [63:0]    STEP_EPS = 64'sd66;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_ORIGIN_X     = 2'd0,
      CSR_ORIGIN_Y     = 2'd1,
      CSR_BULLET_SPEED = 2'd2
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [4:0] {
      S_IDLE,
      S_T2,
      S_VT,
      S_AT2,
      S_DX,
      S_NORM,
      S_AT,
      S_XX,
      S_YY,
      S_SQRT,
      S_RATIO,
      S_BT,
      S_RDX,
      S_PREP,
      S_STEP,
      S_UPD,
      S_CLAMP,
      S_DONE
   } state_type;

   // Multiplier request and response.
   typedef struct packed {
      logic                   start;
      logic signed [MA_W-1:0] a;
      logic signed [MB_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                   done;
      logic signed [MP_W-1:0] prod;
   } mul_rsp_type;

   // Divider request and response (unsigned magnitudes).
   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quo;
   } div_rsp_type;

   // Square root request and response.
   typedef struct packed {
      logic        start;
      logic [63:0] rad;
   } sqrt_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] root;
   } sqrt_rsp_type;

endpackage

### hw/rtl/iaps_mul.sv
// Shift-and-add signed multiplier, one multiplier bit per cycle with early finish.
module iaps_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  iaps_pkg::mul_req_type req,
   output iaps_pkg::mul_rsp_type rsp
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic                           neg_ff, neg_in;
   logic [iaps_pkg::MP_W-1:0]      acc_ff, acc_in;
   logic [iaps_pkg::MP_W-1:0]      ma_ff, ma_in;
   logic [iaps_pkg::MB_W-1:0]      mb_ff, mb_in;
   logic [iaps_pkg::MA_W-1:0]      amag;
   logic [iaps_pkg::MB_W-1:0]      bmag;

   // Operand magnitudes; the sign is applied at the end.
   assign amag = req.a[iaps_pkg::MA_W-1] ? iaps_pkg::MA_W'(-req.a) : iaps_pkg::MA_W'(req.a);
   assign bmag = req.b[iaps_pkg::MB_W-1] ? iaps_pkg::MB_W'(-req.b) : iaps_pkg::MB_W'(req.b);

   // One partial product per cycle until the multiplier runs out of ones.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      if (req.start) begin
         busy_in = 1'b1;
         neg_in  = req.a[iaps_pkg::MA_W-1] ^ req.b[iaps_pkg::MB_W-1];
         acc_in  = '0;
         ma_in   = iaps_pkg::MP_W'(amag);
         mb_in   = bmag;
      end else if (busy_ff) begin
         if (mb_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (mb_ff[0]) begin
               acc_in = acc_ff + ma_ff;
            end
            ma_in = ma_ff << 1;
            mb_in = mb_ff >> 1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Operand and accumulator registers.
   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
   end

   assign rsp.done = done_ff;
   assign rsp.prod = neg_ff ? -$signed(acc_ff) : $signed(acc_ff);

endmodule

### hw/rtl/iaps_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module iaps_div (
   input  logic                  clock,
   input  logic                  reset,
   input  iaps_pkg::div_req_type req,
   output iaps_pkg::div_rsp_type rsp
);

   localparam int CNT_W = $clog2(iaps_pkg::NUM_W);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [iaps_pkg::DEN_W-1:0]    rem_ff, rem_in;
   logic [iaps_pkg::NUM_W-1:0]    quo_ff, quo_in;
   logic [iaps_pkg::DEN_W-1:0]    den_ff, den_in;
   logic [iaps_pkg::DEN_W:0]      trial;
   logic                          fits;

   // Shift the next dividend bit into the partial remainder and try the subtract.
   assign trial = {rem_ff, quo_ff[iaps_pkg::NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(iaps_pkg::NUM_W - 1);
         rem_in  = '0;
         quo_in  = req.num;
         den_in  = req.den;
      end else if (busy_ff) begin
         rem_in = fits ? iaps_pkg::DEN_W'(trial - {1'b0, den_ff}) : iaps_pkg::DEN_W'(trial);
         quo_in = {quo_ff[iaps_pkg::NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

### hw/rtl/iaps_sqrt.sv
// Digit-by-digit integer square root of a 64-bit value, one result bit per cycle.
module iaps_sqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  iaps_pkg::sqrt_req_type req,
   output iaps_pkg::sqrt_rsp_type rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] val_ff, val_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [63:0] trial;

   assign trial = res_ff + bit_ff;

   // Test bit walks down two places a cycle from bit 62 to bit 0.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      val_in  = val_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (req.start) begin
         busy_in = 1'b1;
         val_in  = req.rad;
         res_in  = '0;
         bit_in  = 64'd1 << 62;
      end else if (busy_ff) begin
         if (val_ff >= trial) begin
            val_in = val_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      val_ff <= val_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign rsp.done = done_ff;
   assign rsp.root = res_ff[31:0];

endmodule

### hw/rtl/intercept_aim_point_solver_unit.sv
// Top level: Newton solver for projectile flight time with its sequencer and datapath.
// A Newton iteration uses the shift-and-add multiplier (one multiplier bit per cycle), the
// restoring divider and the digit-by-digit square root. A solve runs up to 20 iterations
// plus one more evaluation of the aim point at the final t; one item is in flight at a
// time and req_ready is high only when idle. Reset is synchronous: it returns the
// sequencer to idle, drops rsp_valid and loads the registers with origin 0,0 and bullet
// speed 30.0.
module intercept_aim_point_solver_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_target_vx,
   input  logic signed [31:0] req_target_ax,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [17:0]        rsp_impact_time,
   output logic signed [31:0] rsp_aim_x,
   output logic signed [31:0] rsp_aim_y
);

   // Configuration registers.
   logic signed [31:0] origin_x_ff, origin_x_in;
   logic signed [31:0] origin_y_ff, origin_y_in;
   logic [30:0]        bullet_speed_ff, bullet_speed_in;

   // Sequencer state.
   iaps_pkg::state_type              state_ff, state_in;
   logic                             issued_ff, issued_in;
   logic                             fin_ff, fin_in;
   logic [iaps_pkg::ITER_W-1:0]      iter_ff, iter_in;

   // Item and iteration datapath.
   logic signed [31:0]                  x_ff, x_in;
   logic signed [31:0]                  vx_ff, vx_in;
   logic signed [31:0]                  ax_ff, ax_in;
   logic signed [31:0]                  y_ff, y_in;
   logic signed [32:0]                  dy_ff, dy_in;
   logic signed [iaps_pkg::T_W-1:0]     t_ff, t_in;
   logic signed [iaps_pkg::T2_W-1:0]    t2_ff, t2_in;
   logic signed [iaps_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                                dxneg_ff, dxneg_in;
   logic [iaps_pkg::MAG_W-1:0]          xs_ff, xs_in;
   logic [iaps_pkg::MAG_W-1:0]          ys_ff, ys_in;
   logic [iaps_pkg::SH_W-1:0]           sh_ff, sh_in;
   logic signed [iaps_pkg::DXDT_W-1:0]  dxdt_ff, dxdt_in;
   logic [63:0]                         sumsq_ff, sumsq_in;
   logic [31:0]                         root_ff, root_in;
   logic [iaps_pkg::DIST_W-1:0]         dist_ff, dist_in;
   logic signed [iaps_pkg::RAT_W-1:0]   ratio_ff, ratio_in;
   logic signed [iaps_pkg::F_W-1:0]     f_ff, f_in;
   logic signed [iaps_pkg::DF_W-1:0]    df_ff, df_in;
   logic signed [63:0]                  step_ff, step_in;

   // Result register.
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [iaps_pkg::OUT_T_W-1:0]        time_ff, time_in;
   logic signed [31:0]                  aim_x_ff, aim_x_in;
   logic signed [31:0]                  aim_y_ff, aim_y_in;

   // Shared units.
   iaps_pkg::mul_req_type  mul_req;
   iaps_pkg::mul_rsp_type  mul_rsp;
   iaps_pkg::div_req_type  div_req;
   iaps_pkg::div_rsp_type  div_rsp;
   iaps_pkg::sqrt_req_type sqrt_req;
   iaps_pkg::sqrt_rsp_type sqrt_rsp;

   // Helper values.
   logic signed [63:0]                 pshr16, pshr17, pshr24;
   logic signed [iaps_pkg::POS_W-1:0]  dx;
   logic signed [63:0]                 t_next;
   logic [iaps_pkg::F_W-1:0]           f_mag;
   logic [iaps_pkg::DF_W-1:0]          df_mag;
   logic [iaps_pkg::RAT_W-1:0]         ratio_mag;
   logic [iaps_pkg::POS_W-32:0]        pos_hi;
   logic                               small_step;
   logic                               last_iter;
   logic                               load_rsp;

   iaps_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   iaps_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   iaps_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sqrt_req),
      .rsp   (sqrt_rsp)
   );

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == iaps_pkg::S_IDLE);

   // Products scaled back with rounding toward minus infinity.
   assign pshr16 = mul_rsp.prod >>> 16;
   assign pshr17 = mul_rsp.prod >>> 17;
   assign pshr24 = mul_rsp.prod >>> 24;

   assign dx         = pos_ff - iaps_pkg::POS_W'(origin_x_ff);
   assign t_next     = 64'(t_ff) - step_ff;
   assign f_mag      = f_ff[iaps_pkg::F_W-1] ? iaps_pkg::F_W'(-f_ff) : iaps_pkg::F_W'(f_ff);
   assign df_mag     = df_ff[iaps_pkg::DF_W-1] ? iaps_pkg::DF_W'(-df_ff) : iaps_pkg::DF_W'(df_ff);
   assign ratio_mag  = div_rsp.quo[iaps_pkg::RAT_W-1:0];
   assign pos_hi     = pos_ff[iaps_pkg::POS_W-1:31];
   assign small_step = (step_ff > -iaps_pkg::STEP_EPS) && (step_ff < iaps_pkg::STEP_EPS);
   assign last_iter  = (iter_ff == iaps_pkg::ITER_W'(iaps_pkg::MAX_ITERATIONS - 1));
   assign load_rsp   = (state_ff == iaps_pkg::S_DONE) && (!rsp_valid_ff || rsp_ready);

   // Operand selection for the shared units; each unit state starts its unit once.
   always_comb begin
      mul_req.start  = 1'b0;
      mul_req.a      = iaps_pkg::MA_W'(vx_ff);
      mul_req.b      = iaps_pkg::MB_W'(t_ff);
      div_req.start  = 1'b0;
      div_req.num    = iaps_pkg::NUM_W'({xs_ff[30:0], 24'd0});
      div_req.den    = iaps_pkg::DEN_W'(root_ff);
      sqrt_req.start = 1'b0;
      sqrt_req.rad   = sumsq_ff;
      case (state_ff)
         iaps_pkg::S_T2: begin
            mul_req.start = !issued_ff;
            mul_req.a     = iaps_pkg::MA_W'(t_ff);
         end
         iaps_pkg::S_VT: begin
            mul_req.start = !issued_ff;
         end
         iaps_pkg::S_AT2: begin
            mul_req.start = !issued_ff;
            mul_req.a     = iaps_pkg::MA_W'(ax_ff);
            mul_req.b     = iaps_pkg::MB_W'(t2_ff);
         end
         iaps_pkg::S_AT: begin
            mul_req.start = !issued_ff;
            mul_req.a     = iaps_pkg::MA_W'(ax_ff);
         end
         iaps_pkg::S_XX: begin
            mul_req.start = !issued_ff;
            mul_req.a     = iaps_pkg::MA_W'(xs_ff[30:0]);
            mul_req.b     = iaps_pkg::MB_W'(xs_ff[30:0]);
         end
         iaps_pkg::S_YY: begin
            mul_req.start = !issued_ff;
            mul_req.a     = iaps_pkg::MA_W'(ys_ff[30:0]);
            mul_req.b     = iaps_pkg::MB_W'(ys_ff[30:0]);
         end
         iaps_pkg::S_BT: begin
            mul_req.start = !issued_ff;
            mul_req.a     = iaps_pkg::MA_W'(bullet_speed_ff);
         end
         iaps_pkg::S_RDX: begin
            mul_req.start = !issued_ff;
            mul_req.a     = dxdt_ff;
            mul_req.b     = iaps_pkg::MB_W'(ratio_ff);
         end
         iaps_pkg::S_SQRT: begin
            sqrt_req.start = !issued_ff;
         end
         iaps_pkg::S_RATIO: begin
            div_req.start = !issued_ff;
         end
         iaps_pkg::S_STEP: begin
            div_req.start = !issued_ff;
            div_req.num   = {f_mag[iaps_pkg::NUM_W-17:0], 16'd0};
            div_req.den   = df_mag;
         end
         default: begin
         end
      endcase
   end

   // Sequencer next state and datapath updates.
   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff | mul_req.start | div_req.start | sqrt_req.start;
      fin_in       = fin_ff;
      iter_in      = iter_ff;
      x_in         = x_ff;
      vx_in        = vx_ff;
      ax_in        = ax_ff;
      y_in         = y_ff;
      dy_in        = dy_ff;
      t_in         = t_ff;
      t2_in        = t2_ff;
      pos_in       = pos_ff;
      dxneg_in     = dxneg_ff;
      xs_in        = xs_ff;
      ys_in        = ys_ff;
      sh_in        = sh_ff;
      dxdt_in      = dxdt_ff;
      sumsq_in     = sumsq_ff;
      root_in      = root_ff;
      dist_in      = dist_ff;
      ratio_in     = ratio_ff;
      f_in         = f_ff;
      df_in        = df_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      time_in      = time_ff;
      aim_x_in     = aim_x_ff;
      aim_y_in     = aim_y_ff;

      // Configuration writes.
      origin_x_in     = origin_x_ff;
      origin_y_in     = origin_y_ff;
      bullet_speed_in = bullet_speed_ff;
      if (csr_valid && csr_ready) begin
         case (iaps_pkg::csr_index_type'(csr_index))
            iaps_pkg::CSR_ORIGIN_X:     origin_x_in     = csr_data;
            iaps_pkg::CSR_ORIGIN_Y:     origin_y_in     = csr_data;
            iaps_pkg::CSR_BULLET_SPEED: bullet_speed_in = csr_data[30:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         iaps_pkg::S_IDLE: begin
            issued_in = 1'b0;
            if (req_valid) begin
               x_in     = req_target_x;
               y_in     = req_target_y;
               vx_in    = req_target_vx;
               ax_in    = req_target_ax;
               dy_in    = 33'(req_target_y) - 33'(origin_y_ff);
               t_in     = iaps_pkg::T_START;
               iter_in  = '0;
               fin_in   = 1'b0;
               state_in = iaps_pkg::S_T2;
            end
         end
         // x(t) = x + vx*t + ax*t*t/2
         iaps_pkg::S_T2: begin
            if (mul_rsp.done) begin
               t2_in     = iaps_pkg::T2_W'(pshr16);
               issued_in = 1'b0;
               state_in  = iaps_pkg::S_VT;
            end
         end
         iaps_pkg::S_VT: begin
            if (mul_rsp.done) begin
               pos_in    = iaps_pkg::POS_W'(x_ff) + iaps_pkg::POS_W'(pshr16);
               issued_in = 1'b0;
               state_in  = iaps_pkg::S_AT2;
            end
         end
         iaps_pkg::S_AT2: begin
            if (mul_rsp.done) begin
               pos_in    = pos_ff + iaps_pkg::POS_W'(pshr17);
               issued_in = 1'b0;
               state_in  = fin_ff ? iaps_pkg::S_DONE : iaps_pkg::S_DX;
            end
         end
         // Offsets from the shooter as magnitudes, then normalize below 2^31.
         iaps_pkg::S_DX: begin
            dxneg_in = dx[iaps_pkg::POS_W-1];
            xs_in    = dx[iaps_pkg::POS_W-1] ? iaps_pkg::MAG_W'(-dx) : iaps_pkg::MAG_W'(dx);
            ys_in    = dy_ff[32] ? iaps_pkg::MAG_W'(-dy_ff) : iaps_pkg::MAG_W'(dy_ff);
            sh_in    = '0;
            state_in = iaps_pkg::S_NORM;
         end
         iaps_pkg::S_NORM: begin
            if ((xs_ff[iaps_pkg::MAG_W-1:31] != '0) || (ys_ff[iaps_pkg::MAG_W-1:31] != '0)) begin
               xs_in = xs_ff >> 1;
               ys_in = ys_ff >> 1;
               sh_in = sh_ff + 1'b1;
            end else begin
               state_in = iaps_pkg::S_AT;
            end
         end
         iaps_pkg::S_AT: begin
            if (mul_rsp.done) begin
               dxdt_in   = iaps_pkg::DXDT_W'(vx_ff) + iaps_pkg::DXDT_W'(pshr16);
               issued_in = 1'b0;
               state_in  = iaps_pkg::S_XX;
            end
         end
         iaps_pkg::S_XX: begin
            if (mul_rsp.done) begin
               sumsq_in  = mul_rsp.prod;
               issued_in = 1'b0;
               state_in  = iaps_pkg::S_YY;
            end
         end
         iaps_pkg::S_YY: begin
            if (mul_rsp.done) begin
               sumsq_in  = sumsq_ff + mul_rsp.prod;
               issued_in = 1'b0;
               state_in  = iaps_pkg::S_SQRT;
            end
         end
         // Zero distance ends the loop with no Newton update and goes on to the clamp.
         iaps_pkg::S_SQRT: begin
            if (sqrt_rsp.done) begin
               root_in   = sqrt_rsp.root;
               dist_in   = iaps_pkg::DIST_W'(sqrt_rsp.root) << sh_ff;
               issued_in = 1'b0;
               state_in  = (sqrt_rsp.root == '0) ? iaps_pkg::S_CLAMP : iaps_pkg::S_RATIO;
            end
         end
         iaps_pkg::S_RATIO: begin
            if (div_rsp.done) begin
               ratio_in  = dxneg_ff ? -$signed(ratio_mag) : $signed(ratio_mag);
               issued_in = 1'b0;
               state_in  = iaps_pkg::S_BT;
            end
         end
         // Residual f = dist - speed*t.
         iaps_pkg::S_BT: begin
            if (mul_rsp.done) begin
               f_in      = iaps_pkg::F_W'(dist_ff) - iaps_pkg::F_W'(pshr16);
               issued_in = 1'b0;
               state_in  = iaps_pkg::S_RDX;
            end
         end
         // Derivative df = ratio*dxdt - speed.
         iaps_pkg::S_RDX: begin
            if (mul_rsp.done) begin
               df_in     = iaps_pkg::DF_W'(pshr24) - iaps_pkg::DF_W'(bullet_speed_ff);
               issued_in = 1'b0;
               state_in  = iaps_pkg::S_PREP;
            end
         end
         // A zero derivative ends the loop with no Newton update and goes on to the clamp.
         iaps_pkg::S_PREP: begin
            issued_in = 1'b0;
            state_in  = (df_ff == '0) ? iaps_pkg::S_CLAMP : iaps_pkg::S_STEP;
         end
         iaps_pkg::S_STEP: begin
            if (div_rsp.done) begin
               if (f_ff[iaps_pkg::F_W-1] ^ df_ff[iaps_pkg::DF_W-1]) begin
                  step_in = -$signed(64'(div_rsp.quo));
               end else begin
                  step_in = $signed(64'(div_rsp.quo));
               end
               issued_in = 1'b0;
               state_in  = iaps_pkg::S_UPD;
            end
         end
         // Newton update with saturation; a small step or the last iteration ends the loop.
         iaps_pkg::S_UPD: begin
            if (t_next > iaps_pkg::T_SAT) begin
               t_in = iaps_pkg::T_W'(iaps_pkg::T_SAT);
            end else if (t_next < -iaps_pkg::T_SAT) begin
               t_in = iaps_pkg::T_W'(-iaps_pkg::T_SAT);
            end else begin
               t_in = iaps_pkg::T_W'(t_next);
            end
            iter_in  = iter_ff + 1'b1;
            state_in = (small_step || last_iter) ? iaps_pkg::S_CLAMP : iaps_pkg::S_T2;
         end
         // Clamp t, then evaluate the aim point once more at the final t.
         iaps_pkg::S_CLAMP: begin
            if (t_ff < iaps_pkg::T_MIN) begin
               t_in = iaps_pkg::T_MIN;
            end else if (t_ff > iaps_pkg::T_MAX) begin
               t_in = iaps_pkg::T_MAX;
            end
            fin_in    = 1'b1;
            issued_in = 1'b0;
            state_in  = iaps_pkg::S_T2;
         end
         // Hand the result over once the output register is free.
         iaps_pkg::S_DONE: begin
            if (load_rsp) begin
               time_in = iaps_pkg::OUT_T_W'(t_ff);
               if ((pos_hi != '0) && (pos_hi != '1)) begin
                  aim_x_in = pos_ff[iaps_pkg::POS_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
               end else begin
                  aim_x_in = pos_ff[31:0];
               end
               aim_y_in     = y_ff;
               rsp_valid_in = 1'b1;
               state_in     = iaps_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = iaps_pkg::S_IDLE;
         end
      endcase
   end

   // State register and control.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= iaps_pkg::S_IDLE;
         issued_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         origin_x_ff     <= '0;
         origin_y_ff     <= '0;
         bullet_speed_ff <= 31'd1966080;
      end else begin
         state_ff        <= state_in;
         issued_ff       <= issued_in;
         rsp_valid_ff    <= rsp_valid_in;
         origin_x_ff     <= origin_x_in;
         origin_y_ff     <= origin_y_in;
         bullet_speed_ff <= bullet_speed_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      fin_ff   <= fin_in;
      iter_ff  <= iter_in;
      x_ff     <= x_in;
      vx_ff    <= vx_in;
      ax_ff    <= ax_in;
      y_ff     <= y_in;
      dy_ff    <= dy_in;
      t_ff     <= t_in;
      t2_ff    <= t2_in;
      pos_ff   <= pos_in;
      dxneg_ff <= dxneg_in;
      xs_ff    <= xs_in;
      ys_ff    <= ys_in;
      sh_ff    <= sh_in;
      dxdt_ff  <= dxdt_in;
      sumsq_ff <= sumsq_in;
      root_ff  <= root_in;
      dist_ff  <= dist_in;
      ratio_ff <= ratio_in;
      f_ff     <= f_in;
      df_ff    <= df_in;
      step_ff  <= step_in;
      time_ff  <= time_in;
      aim_x_ff <= aim_x_in;
      aim_y_ff <= aim_y_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_impact_time = time_ff;
   assign rsp_aim_x       = aim_x_ff;
   assign rsp_aim_y       = aim_y_ff;

endmodule

### hw/rtl/iaps_checker.sv
// Port-level checker for the intercept aim point solver, bound to the top level.
module iaps_checker (
   input logic               clock,
   input logic               reset,
   input logic               csr_valid,
   input logic               csr_ready,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [17:0]        rsp_impact_time,
   input logic signed [31:0] rsp_aim_x
);

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_impact_time) && $stable(rsp_aim_x))
      else $error("result changed while stalled");

   // The solver takes no new item right after accepting one.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after a transfer");

   // The flight time stays inside the clamp range.
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_impact_time >= 18'd655) && (rsp_impact_time <= 18'd196608))
      else $error("impact time outside clamp range");

   // Configuration writes are always taken.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write stalled");

endmodule

bind intercept_aim_point_solver_unit iaps_checker u_iaps_checker (.*);
